>>> sv/seat_grid_toggle_and_run_allocate_macros.svh
// ----------------------------------------------------------------------------
// seat grid assertion macros
// shared property forms for the seat grid checks, clocked on clk and
// disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SEAT_GRID_TOGGLE_AND_RUN_ALLOCATE_MACROS_SVH
`define SEAT_GRID_TOGGLE_AND_RUN_ALLOCATE_MACROS_SVH

// condition holds in the same cycle
`define SGT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define SGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg
// types, seat codes and fixed seat geometry for the seat grid block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgt_pkg;

  // seat status codes
  localparam logic [1:0] SEAT_FREE   = 2'd0;
  localparam logic [1:0] SEAT_RSVD   = 2'd1;
  localparam logic [1:0] SEAT_BOUGHT = 2'd2;

  // command codes
  localparam logic CMD_CLICK = 1'b0;
  localparam logic CMD_BUY   = 1'b1;

  // geometry in doubled q2.14 units
  localparam int unsigned GEO_W = 19;
  typedef logic signed [GEO_W-1:0] geo_t;

  localparam geo_t Y2_BASE  = GEO_W'(-24576);
  localparam geo_t Y2_PITCH = GEO_W'(4680);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLK_SCAN,
    S_CLK_UPD,
    S_BUY_SCAN,
    S_BUY_WR,
    S_DONE
  } state_t;

  // one result beat, hit_found in the lowest bit
  typedef struct packed {
    logic [3:0] buy_right_col;
    logic [2:0] buy_row;
    logic       buy_done;
    logic [1:0] new_status;
    logic [6:0] hit_seat;
    logic       hit_found;
  } result_t;

  // half size of a seat per row
  function automatic logic [10:0] row_half(input logic [3:0] r);
    logic [10:0] v;
    case (r)
      4'd0:    v = 11'd1671;
      4'd1:    v = 11'd1532;
      4'd2:    v = 11'd1393;
      4'd3:    v = 11'd1253;
      4'd4:    v = 11'd1114;
      4'd5:    v = 11'd1044;
      default: v = 11'd1393;
    endcase
    return v;
  endfunction

  // column pitch per row
  function automatic logic [10:0] row_step(input logic [3:0] r);
    logic [10:0] v;
    case (r)
      4'd0:    v = 11'd2005;
      4'd1:    v = 11'd1838;
      4'd2:    v = 11'd1671;
      4'd3:    v = 11'd1504;
      4'd4:    v = 11'd1337;
      4'd5:    v = 11'd1253;
      default: v = 11'd1671;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/seat_grid_toggle_and_run_allocate.sv
// A click scans the seat boxes in index order, one seat box tested per cycle
// by the shared hit-test unit, then loads its result into the output register.
// A buy scans row by row, right to left, one status read per cycle
// from the single read port, then marks each seat bought and loads the result.
// One item at a time: in_tready is high only while the sequencer is idle.
// Reset (synchronous, rst_n low) clears the sequencer and marks every seat free.
// ----------------------------------------------------------------------------
// seat_grid_toggle_and_run_allocate
// seat grid with click toggle and run purchase, run by a small sequencer
// over a shared hit-test unit and a one-read one-write seat status store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seat_grid_toggle_and_run_allocate #(
  parameter int ROWS = 6,
  parameter int COLS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // click_x[15:0], click_y[31:16], seat_count[35:32]
  input  wire logic        in_tuser,  // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata  // hit_found, hit_seat, new_status, buy_done,
                                      // buy_row, buy_right_col
);
  import sgt_pkg::*;

`include "seat_grid_toggle_and_run_allocate_macros.svh"

  localparam int NSEATS = ROWS * COLS;
  localparam int AW     = (NSEATS > 1) ? $clog2(NSEATS) : 1;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW     = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
  localparam logic [AW-1:0] IDX_ROW0 = AW'(COLS - 1);
  localparam logic [AW-1:0] IDX_JUMP = AW'(2 * COLS - 1);
  localparam logic [4:0]    COLS_W   = 5'(COLS);
  localparam geo_t          COL_SPAN = GEO_W'(COLS - 1);

  // x centre of the leftmost seat of a row
  function automatic geo_t x_first(input logic [3:0] r);
    geo_t s;
    s = GEO_W'(row_step(r));
    return -(s * COL_SPAN);
  endfunction

  state_t        state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  geo_t          x2_r, x2_nxt;
  geo_t          y2_r, y2_nxt;
  geo_t          px2_r, px2_nxt;
  geo_t          py2_r, py2_nxt;
  logic [3:0]    n_r, n_nxt;
  logic [3:0]    run_r, run_nxt;       // run length in scan, seats left in write
  logic [CW-1:0] right_col_r, right_col_nxt;
  logic [AW-1:0] right_idx_r, right_idx_nxt;
  logic          iss_act_r, iss_act_nxt;
  logic          ev_vld_r, ev_vld_nxt;
  logic [RW-1:0] ev_row_r, ev_row_nxt;
  logic [CW-1:0] ev_col_r, ev_col_nxt;
  logic [AW-1:0] ev_idx_r, ev_idx_nxt;
  result_t       res_r, res_nxt;
  result_t       out_res_r, out_res_nxt;
  logic          out_vld_r, out_vld_nxt;

  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [1:0]    mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [1:0]    mem_wr_data;

  geo_t          h2;
  logic          hit;

  // per-row seat half size
  assign h2 = GEO_W'({row_half(4'(row_r)), 1'b0});

  sgt_seat_window u_window (
    .px2     (px2_r),
    .py2     (py2_r),
    .x2      (x2_r),
    .y2      (y2_r),
    .h2      (h2),
    .box_hit (hit)
  );

  sgt_seat_mem #(
    .DEPTH (NSEATS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      iss_act_r <= 1'b0;
      ev_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iss_act_r <= iss_act_nxt;
      ev_vld_r  <= ev_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    idx_r       <= idx_nxt;
    x2_r        <= x2_nxt;
    y2_r        <= y2_nxt;
    px2_r       <= px2_nxt;
    py2_r       <= py2_nxt;
    n_r         <= n_nxt;
    run_r       <= run_nxt;
    right_col_r <= right_col_nxt;
    right_idx_r <= right_idx_nxt;
    ev_row_r    <= ev_row_nxt;
    ev_col_r    <= ev_col_nxt;
    ev_idx_r    <= ev_idx_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  // sequencer next state and datapath control
  always_comb begin
    logic [3:0]    run_base;
    logic [CW-1:0] rc;
    logic [AW-1:0] ri;
    logic [1:0]    new_st;

    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    idx_nxt       = idx_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    px2_nxt       = px2_r;
    py2_nxt       = py2_r;
    n_nxt         = n_r;
    run_nxt       = run_r;
    right_col_nxt = right_col_r;
    right_idx_nxt = right_idx_r;
    iss_act_nxt   = iss_act_r;
    ev_vld_nxt    = 1'b0;
    ev_row_nxt    = row_r;
    ev_col_nxt    = col_r;
    ev_idx_nxt    = idx_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = idx_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = right_idx_r;
    mem_wr_data   = SEAT_BOUGHT;
    in_tready     = 1'b0;
    run_base      = '0;
    rc            = right_col_r;
    ri            = right_idx_r;
    new_st        = SEAT_FREE;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          res_nxt = '0;
          px2_nxt = GEO_W'(signed'({in_tdata[15:0], 1'b0}));
          py2_nxt = GEO_W'(signed'({in_tdata[31:16], 1'b0}));
          n_nxt   = in_tdata[35:32];
          run_nxt = '0;
          if (in_tuser == CMD_CLICK) begin
            row_nxt   = '0;
            col_nxt   = '0;
            idx_nxt   = '0;
            x2_nxt    = x_first(4'd0);
            y2_nxt    = Y2_BASE;
            state_nxt = S_CLK_SCAN;
          end else if ((in_tdata[35:32] == 4'd0) || ({1'b0, in_tdata[35:32]} > COLS_W)) begin
            state_nxt = S_DONE;
          end else begin
            row_nxt     = '0;
            col_nxt     = COL_LAST;
            idx_nxt     = IDX_ROW0;
            iss_act_nxt = 1'b1;
            state_nxt   = S_BUY_SCAN;
          end
        end
      end

      // one seat box per cycle in index order
      S_CLK_SCAN: begin
        if (hit) begin
          mem_rd_en = 1'b1;
          state_nxt = S_CLK_UPD;
        end else if (col_r == COL_LAST) begin
          if (row_r == ROW_LAST) begin
            state_nxt = S_DONE;
          end else begin
            row_nxt = row_r + 1'b1;
            col_nxt = '0;
            idx_nxt = idx_r + 1'b1;
            x2_nxt  = x_first(4'(row_r) + 4'd1);
            y2_nxt  = y2_r + Y2_PITCH;
          end
        end else begin
          col_nxt = col_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
          x2_nxt  = x2_r + GEO_W'({row_step(4'(row_r)), 1'b0});
        end
      end

      // toggle free and reserved, bought stays
      S_CLK_UPD: begin
        case (mem_rd_data)
          SEAT_FREE: new_st = SEAT_RSVD;
          SEAT_RSVD: new_st = SEAT_FREE;
          default:   new_st = mem_rd_data;
        endcase
        mem_wr_en          = 1'b1;
        mem_wr_addr        = idx_r;
        mem_wr_data        = new_st;
        res_nxt.hit_found  = 1'b1;
        res_nxt.hit_seat   = 7'(idx_r);
        res_nxt.new_status = new_st;
        state_nxt          = S_DONE;
      end

      // each read is issued in the cycle before its run check
      S_BUY_SCAN: begin
        if (iss_act_r) begin
          mem_rd_en  = 1'b1;
          ev_vld_nxt = 1'b1;
          if (col_r == '0) begin
            if (row_r == ROW_LAST) begin
              iss_act_nxt = 1'b0;
            end else begin
              row_nxt = row_r + 1'b1;
              col_nxt = COL_LAST;
              idx_nxt = idx_r + IDX_JUMP;
            end
          end else begin
            col_nxt = col_r - 1'b1;
            idx_nxt = idx_r - 1'b1;
          end
        end
        if (ev_vld_r) begin
          run_base = (ev_col_r == COL_LAST) ? 4'd0 : run_r;
          if (mem_rd_data == SEAT_FREE) begin
            rc = (run_base == 4'd0) ? ev_col_r : right_col_r;
            ri = (run_base == 4'd0) ? ev_idx_r : right_idx_r;
            right_col_nxt = rc;
            right_idx_nxt = ri;
            run_nxt       = run_base + 4'd1;
          end else begin
            run_nxt = '0;
          end
          if ((mem_rd_data == SEAT_FREE) && ((run_base + 4'd1) == n_r)) begin
            run_nxt               = n_r;
            iss_act_nxt           = 1'b0;
            ev_vld_nxt            = 1'b0;
            res_nxt.buy_done      = 1'b1;
            res_nxt.buy_row       = 3'(ev_row_r);
            res_nxt.buy_right_col = 4'(rc);
            state_nxt             = S_BUY_WR;
          end else if ((ev_row_r == ROW_LAST) && (ev_col_r == '0)) begin
            iss_act_nxt = 1'b0;
            ev_vld_nxt  = 1'b0;
            state_nxt   = S_DONE;
          end
        end
      end

      // mark the run bought, right to left
      S_BUY_WR: begin
        mem_wr_en     = 1'b1;
        right_idx_nxt = right_idx_r - 1'b1;
        run_nxt       = run_r - 4'd1;
        if (run_r == 4'd1) begin
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_res_nxt = res_r;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_res_r};

  // checks
  `SGT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accept")
  `SGT_ASSERT_NOW(a_write_state, mem_wr_en, (state_r == S_CLK_UPD) || (state_r == S_BUY_WR), "status write outside update")
  `SGT_ASSERT_NOW(a_wr_count, state_r == S_BUY_WR, run_r != 4'd0, "buy write with no seats left")
  `SGT_ASSERT_NOW(a_one_kind, out_tvalid, !(out_tdata[0] && out_tdata[10]), "hit and buy in one beat")
  `SGT_ASSERT_NOW(a_run_short, (state_r == S_BUY_SCAN) && ev_vld_r, run_r < n_r, "run reached count unnoticed")

endmodule

`default_nettype wire

>>> sv/sgt_seat_mem.sv
// ----------------------------------------------------------------------------
// sgt_seat_mem
// seat status store, one write and one registered read per cycle; per-entry
// valid flags make untouched seats read as free after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgt_seat_mem #(
  parameter int DEPTH = 84,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [1:0]         rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [1:0]    wr_data
);
  import sgt_pkg::*;

  logic [1:0]       mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [1:0]       rd_data_r;

  // valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem_r[rd_addr] : SEAT_FREE;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/sgt_seat_window.sv
// ----------------------------------------------------------------------------
// sgt_seat_window
// shared hit-test unit: strict inside test of a point against one seat box
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgt_seat_window (
  input  wire sgt_pkg::geo_t px2,
  input  wire sgt_pkg::geo_t py2,
  input  wire sgt_pkg::geo_t x2,
  input  wire sgt_pkg::geo_t y2,
  input  wire sgt_pkg::geo_t h2,
  output logic               box_hit
);
  import sgt_pkg::*;

  geo_t x_lo;
  geo_t x_hi;
  geo_t y_lo;
  geo_t y_hi;

  // box edges
  assign x_lo = x2 - h2;
  assign x_hi = x2 + h2;
  assign y_lo = y2 - h2;
  assign y_hi = y2 + h2;

  // all four bounds strict
  assign box_hit = (px2 > x_lo) && (px2 < x_hi) && (py2 > y_lo) && (py2 < y_hi);

endmodule

`default_nettype wire

>>> tb/seat_grid_checker.sv
// ----------------------------------------------------------------------------
// seat grid checker
// watches both stream channels of the seat grid block, keeps its own copy of
// the seat map, works out the result of every accepted command beat and
// compares each result beat field by field with the oldest one outstanding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seat_grid_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // click_x[15:0], click_y[31:16], seat_count[35:32]
  input  logic        in_tuser,   // cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // hit_found, hit_seat, new_status, buy_done,
                                  // buy_row, buy_right_col
  output int          fail_count,
  output int          open_count
);

  import sgt_pkg::*;

  localparam int ROWS  = 6;
  localparam int COLS  = 14;
  localparam int SEATS = ROWS * COLS;

  logic [1:0] seat_map [SEATS];
  result_t    pending_results [$];

  // half size of a seat box in each row, q2.14
  function automatic int box_half(input int r);
    int v;
    case (r)
      0: v = 1671;
      1: v = 1532;
      2: v = 1393;
      3: v = 1253;
      4: v = 1114;
      5: v = 1044;
      default: v = 1393;
    endcase
    return v;
  endfunction

  // distance between seat centers in each row, q2.14
  function automatic int box_pitch(input int r);
    int v;
    case (r)
      0: v = 2005;
      1: v = 1838;
      2: v = 1671;
      3: v = 1504;
      4: v = 1337;
      5: v = 1253;
      default: v = 1671;
    endcase
    return v;
  endfunction

  // apply one command to the seat map and return the result beat it gives
  function automatic result_t apply_command(input logic cmd, input logic signed [15:0] cx,
                                            input logic signed [15:0] cy,
                                            input logic [3:0] count);
    result_t res;
    int px2, py2, h2, x2, y2, idx, run, right;
    res = '0;
    if (cmd == CMD_CLICK) begin
      // hit test in doubled units so that seat centers stay exact
      px2 = cx * 2;
      py2 = cy * 2;
      for (int r = 0; r < ROWS; r++) begin
        h2 = 2 * box_half(r);
        y2 = 2 * (-12288 + 2340 * r);
        for (int c = 0; c < COLS; c++) begin
          x2 = box_pitch(r) * (2 * c - (COLS - 1));
          if (px2 > x2 - h2 && px2 < x2 + h2 && py2 > y2 - h2 && py2 < y2 + h2) begin
            idx = r * COLS + c;
            if (seat_map[idx] == SEAT_FREE)
              seat_map[idx] = SEAT_RSVD;
            else if (seat_map[idx] == SEAT_RSVD)
              seat_map[idx] = SEAT_FREE;
            res.hit_found  = 1'b1;
            res.hit_seat   = 7'(idx);
            res.new_status = seat_map[idx];
            return res;
          end
        end
      end
      return res;
    end
    // purchase: bottom row first, right to left within a row
    if (count == 0 || count > COLS)
      return res;
    for (int r = 0; r < ROWS; r++) begin
      run = 0;
      right = 0;
      for (int c = COLS - 1; c >= 0; c--) begin
        if (seat_map[r * COLS + c] == SEAT_FREE) begin
          if (run == 0)
            right = c;
          run++;
          if (run == count) begin
            for (int k = 0; k < run; k++)
              seat_map[r * COLS + right - k] = SEAT_BOUGHT;
            res.buy_done      = 1'b1;
            res.buy_row       = 3'(r);
            res.buy_right_col = 4'(right);
            return res;
          end
        end else begin
          run = 0;
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // result beats first, so a command beat on the same edge never pairs with them
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      foreach (seat_map[i])
        seat_map[i] = SEAT_FREE;
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(result_t)-1:0];
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with none outstanding, expected none actual %h",
                   $time, got);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("hit_found", want.hit_found, got.hit_found);
          check_field("hit_seat", want.hit_seat, got.hit_seat);
          check_field("new_status", want.new_status, got.new_status);
          check_field("buy_done", want.buy_done, got.buy_done);
          check_field("buy_row", want.buy_row, got.buy_row);
          check_field("buy_right_col", want.buy_right_col, got.buy_right_col);
        end
      end
      // append the predicted beat at the tail of the outstanding list
      if (in_tvalid && in_tready)
        pending_results = {pending_results,
                           apply_command(in_tuser, in_tdata[15:0], in_tdata[31:16],
                                         in_tdata[35:32])};
    end
    open_count = pending_results.size();
  end

endmodule

>>> tb/seat_grid_toggle_and_run_allocate_test.sv
// ----------------------------------------------------------------------------
// seat grid block test
// drives click and purchase beats into the seat grid block: a directed run
// over the field extremes, the strict box edges, overlapping rows and the
// purchase corner cases, then random clicks aimed at seats mixed with random
// purchases, with bursts of idling on both channels; the checker judges
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seat_grid_toggle_and_run_allocate_test;

  import sgt_pkg::*;

  localparam int RANDOM_BEATS = 1000;
  localparam int CALM_BEATS   = 100;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tuser   = CMD_CLICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int fail_count;
  int open_count;
  int cycle_count = 0;
  int stall_left  = 0;
  bit in_gaps     = 1'b1;
  bit out_gaps    = 1'b1;

  seat_grid_toggle_and_run_allocate #(
    .ROWS(6),
    .COLS(14)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  seat_grid_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .open_count(open_count)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL seat_grid_toggle_and_run_allocate");
      $finish;
    end
  end

  // result side: ready, with random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_gaps && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // column pitch per row, only for aiming clicks at seats
  function automatic int aim_pitch(input int r);
    int v;
    case (r)
      0: v = 2005;
      1: v = 1838;
      2: v = 1671;
      3: v = 1504;
      4: v = 1337;
      default: v = 1253;
    endcase
    return v;
  endfunction

  // one command beat, then maybe a gap of random length
  task automatic feed(input logic cmd, input logic signed [15:0] cx,
                      input logic signed [15:0] cy, input logic [3:0] count);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, count, cy, cx};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic click(input int cx, input int cy);
    feed(CMD_CLICK, 16'(cx), 16'(cy), 4'($urandom));
  endtask

  task automatic buy(input int count);
    feed(CMD_BUY, 16'($urandom), 16'($urandom), 4'(count));
  endtask

  initial begin
    int r, c, cx, cy;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, all outside the grid
    click(-32768, -32768);
    click(32767, 32767);
    click(32767, -32768);
    click(-32768, 32767);
    // bottom left seat reserved, then freed again
    click(-13032, -12288);
    click(-13032, -12288);
    // top right seat
    click(8144, -588);
    // strict left edge of the first seat of row 1, then one step inside
    click(-13479, -9948);
    click(-13478, -9948);
    // strict lower edge of the bottom left seat, then one step inside
    click(-13032, -13959);
    click(-13032, -13958);
    // point inside both row 0 and row 1 boxes: the lower index wins
    click(-12000, -11000);
    // zero and oversized counts buy nothing
    buy(0);
    buy(15);
    // a whole row, then a bought seat clicked
    buy(14);
    click(-13032, -12288);
    // full row past a row blocked by a reserved seat, then shorter runs
    buy(14);
    buy(13);
    buy(1);
    buy(3);
    buy(14);
    buy(14);

    // random part: mostly clicks aimed at seats, some noise, few purchases
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      in_gaps  = (i < RANDOM_BEATS - CALM_BEATS) && ((i / 150) % 3 != 2);
      out_gaps = in_gaps;
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 9) < 7)
          buy($urandom_range(1, 4));
        else
          buy($urandom_range(0, 15));
      end else if ($urandom_range(0, 3) != 0) begin
        r  = $urandom_range(0, 5);
        c  = $urandom_range(0, 13);
        cx = aim_pitch(r) * (2 * c - 13) / 2 + int'($urandom_range(0, 3800)) - 1900;
        cy = -12288 + 2340 * r + int'($urandom_range(0, 3800)) - 1900;
        click(cx, cy);
      end else begin
        click(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
      end
    end
    in_tvalid <= 1'b0;

    // drain, then allow the block's worst case latency
    do @(posedge clk); while (open_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS seat_grid_toggle_and_run_allocate");
    else
      $display("FAIL seat_grid_toggle_and_run_allocate");
    $finish;
  end

endmodule
